// File: design/qpm_pkg.sv
// shared constants and types for the quad perspective matrix setup block
package qpm_pkg;

    // configuration port
    localparam int CFG_W     = 32;
    localparam int REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LEFT   = 2'd0,
        REG_TOP    = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } reg_idx_t;

    // reset values of the source rectangle, 320.0 by 400.0 in Q16.16
    localparam logic [CFG_W-1:0] RESET_WIDTH  = 32'd20971520;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 32'd26214400;

    // multiplier: operand b is consumed in MUL_STEPS chunks
    localparam int MUL_STEPS = 4;
    localparam int MUL_LAT   = MUL_STEPS + 2;

    // result word: Q24.24 in 48 bits, one quotient bit per divider stage
    localparam int Q_W     = 48;
    localparam int DIV_LAT = Q_W + 3;

    localparam logic [Q_W-1:0] LIM_POS = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] LIM_NEG = {1'b1, {(Q_W-1){1'b0}}};

endpackage

// File: design/qpm_mul.sv
// pipelined signed multiplier, operand b taken a chunk per stage
module qpm_mul
    import qpm_pkg::*;
#(
    parameter int AW = 33,
    parameter int BW = 33
)
(
    input  logic                     clk,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  p
);

    localparam int CW  = (BW + MUL_STEPS - 1) / MUL_STEPS;
    localparam int BPW = CW * MUL_STEPS;
    localparam int PW  = AW + BW;

    logic [AW-1:0]  am_reg  [0:MUL_STEPS-1];
    logic [BPW-1:0] bm_reg  [0:MUL_STEPS-1];
    logic [PW-1:0]  acc_reg [0:MUL_STEPS];
    logic           neg_reg [0:MUL_STEPS];
    logic [PW-1:0]  p_reg;
    logic [AW-1:0]  amag;
    logic [BW-1:0]  bmag;

    // operand magnitudes
    assign amag = a[AW-1] ? AW'(-a) : AW'(a);
    assign bmag = b[BW-1] ? BW'(-b) : BW'(b);

    // magnitude capture, chunked accumulation and final sign
    always_ff @(posedge clk)
    begin
        am_reg[0]  <= amag;
        bm_reg[0]  <= BPW'(bmag);
        acc_reg[0] <= '0;
        neg_reg[0] <= a[AW-1] ^ b[BW-1];
        for (int k = 1; k < MUL_STEPS; k++)
        begin
            am_reg[k] <= am_reg[k-1];
            bm_reg[k] <= bm_reg[k-1] >> CW;
        end
        for (int k = 0; k < MUL_STEPS; k++)
        begin
            acc_reg[k+1] <= acc_reg[k]
                + ((PW'(am_reg[k]) * PW'(bm_reg[k][CW-1:0])) << (CW * k));
            neg_reg[k+1] <= neg_reg[k];
        end
        p_reg <= neg_reg[MUL_STEPS] ? (~acc_reg[MUL_STEPS] + PW'(1))
                                    : acc_reg[MUL_STEPS];
    end

    assign p = signed'(p_reg);

endmodule

// File: design/qpm_div.sv
// pipelined restoring divider, rounded half away from zero, saturated to Q_W bits
module qpm_div
    import qpm_pkg::*;
#(
    parameter int NW = 125,
    parameter int DW = 102
)
(
    input  logic                  clk,
    input  logic signed [NW-1:0]  num,
    input  logic signed [DW-1:0]  den,
    output logic signed [Q_W-1:0] quo
);

    localparam int XW = NW + 1;
    localparam int YW = DW + 1;
    localparam int HW = XW - Q_W;
    localparam int CW = (HW > YW) ? HW : YW;

    logic [NW-1:0]  nmag;
    logic [DW-1:0]  dmag;
    logic [XW-1:0]  x_reg;
    logic [YW-1:0]  y_reg;
    logic           sg_reg;

    logic [YW-1:0]  r_arr  [0:Q_W-1];
    logic [Q_W-1:0] lo_arr [0:Q_W-1];
    logic [YW-1:0]  y_arr  [0:Q_W-1];
    logic [Q_W-1:0] q_arr  [0:Q_W];
    logic           ov_arr [0:Q_W];
    logic           sg_arr [0:Q_W];

    logic [YW:0]    tr [0:Q_W-1];
    logic [YW:0]    nr [0:Q_W-1];
    logic           ge [0:Q_W-1];

    logic [Q_W-1:0] mag;
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] res;
    logic [Q_W-1:0] quo_reg;

    assign nmag = num[NW-1] ? NW'(-num) : NW'(num);
    assign dmag = den[DW-1] ? DW'(-den) : DW'(den);

    // one quotient bit per stage
    always_comb
    begin
        for (int k = 0; k < Q_W; k++)
        begin
            tr[k] = {r_arr[k], lo_arr[k][Q_W-1]};
            ge[k] = tr[k] >= {1'b0, y_arr[k]};
            nr[k] = ge[k] ? (tr[k] - {1'b0, y_arr[k]}) : tr[k];
        end
    end

    // final saturation limit and clamp
    always_comb
    begin
        mag = q_arr[Q_W];
        lim = sg_arr[Q_W] ? LIM_NEG : LIM_POS;
        res = (ov_arr[Q_W] || (mag > lim)) ? lim : mag;
    end

    always_ff @(posedge clk)
    begin
        // rounding folded in: (2n + d) / (2d)
        x_reg  <= XW'({nmag, 1'b0}) + XW'(dmag);
        y_reg  <= {dmag, 1'b0};
        sg_reg <= num[NW-1] ^ den[DW-1];

        // overflow check and leading partial remainder
        ov_arr[0] <= CW'(x_reg[XW-1:Q_W]) >= CW'(y_reg);
        r_arr[0]  <= YW'(x_reg[XW-1:Q_W]);
        lo_arr[0] <= x_reg[Q_W-1:0];
        y_arr[0]  <= y_reg;
        q_arr[0]  <= '0;
        sg_arr[0] <= sg_reg;

        for (int k = 0; k < Q_W - 1; k++)
        begin
            r_arr[k+1]  <= nr[k][YW-1:0];
            lo_arr[k+1] <= {lo_arr[k][Q_W-2:0], 1'b0};
            y_arr[k+1]  <= y_arr[k];
        end
        for (int k = 0; k < Q_W; k++)
        begin
            q_arr[k+1]  <= {q_arr[k][Q_W-2:0], ge[k]};
            ov_arr[k+1] <= ov_arr[k];
            sg_arr[k+1] <= sg_arr[k];
        end

        quo_reg <= sg_arr[Q_W] ? (~res + Q_W'(1)) : res;
    end

    assign quo = signed'(quo_reg);

endmodule

// File: design/quad_perspective_matrix_setup_core.sv
// Square-to-quad perspective matrix setup, fully pipelined. A request is taken in
// every cycle (busy stays low) and its matrix is on the outputs with done, which
// is a single-cycle strobe that the receiver cannot stall. The pipeline is four
// chained multiplier stages (operand b is taken a chunk per stage) followed by
// nine parallel dividers that resolve one quotient bit per stage. Rectangle
// registers are sampled when the request is taken.
module quad_perspective_matrix_setup_core
    import qpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_index,
    input  logic [CFG_W-1:0]      wr_data,
    input  logic signed [31:0]    ul_x,
    input  logic signed [31:0]    ul_y,
    input  logic signed [31:0]    ur_x,
    input  logic signed [31:0]    ur_y,
    input  logic signed [31:0]    ll_x,
    input  logic signed [31:0]    ll_y,
    input  logic signed [31:0]    lr_x,
    input  logic signed [31:0]    lr_y,
    output logic                  done,
    output logic signed [47:0]    m11,
    output logic signed [47:0]    m12,
    output logic signed [47:0]    m14,
    output logic signed [47:0]    m21,
    output logic signed [47:0]    m22,
    output logic signed [47:0]    m24,
    output logic signed [47:0]    m41,
    output logic signed [47:0]    m42,
    output logic signed [47:0]    m44,
    output logic                  degenerate
);

    localparam int TOT = 4 * MUL_LAT + Q_W + 10;

    typedef struct packed {
        logic signed [32:0] ax, ay, bx, by;
        logic signed [31:0] ux, uy;
        logic signed [32:0] w, h;
    } side_t;

    typedef struct packed {
        side_t sd;
        logic  whz;
    } a_t;

    typedef struct packed {
        side_t              sd;
        logic               deg;
        logic signed [67:0] p1, q1;
    } b_t;

    typedef struct packed {
        side_t               sd;
        logic                deg;
        logic signed [100:0] n0, n1, n3, n4;
        logic signed [101:0] d1, d2;
        logic signed [132:0] r1, r2;
        logic signed [133:0] ts;
        logic signed [67:0]  p1, q1;
    } c_t;

    typedef struct packed {
        logic                deg;
        logic signed [100:0] n0, n1, n3, n4;
        logic signed [101:0] d1, d2;
        logic signed [134:0] d3;
        logic signed [135:0] r4;
        logic signed [67:0]  p1, q1;
    } d_t;

    // rectangle registers
    logic [CFG_W-1:0] rect_left_reg, rect_top_reg, rect_width_reg, rect_height_reg;

    // request valid travels down a shift line, the datapath never stalls
    logic [TOT-1:0] vld_reg, vld_next;

    // stage 1: corner differences
    side_t              s1_sd_reg;
    logic signed [32:0] s1_dx_reg, s1_dy_reg;
    logic signed [31:0] s1_l_reg, s1_t_reg;
    logic               s1_whz_reg;

    logic signed [65:0] pa_axby, pa_aybx, pa_bydx, pa_bxdy, pa_axdy, pa_aydx;
    logic signed [64:0] pa_lh, pa_tw;
    a_t                 a_dl_reg [0:MUL_LAT-1];

    // stage 2 and 3: den, a, b and derived terms
    side_t              s2_sd_reg, s3_sd_reg;
    logic signed [66:0] s2_den_reg, s2_an_reg, s2_bn_reg;
    logic signed [64:0] s2_lh_reg, s2_tw_reg, s3_lh_reg, s3_tw_reg;
    logic               s2_whz_reg, s3_deg_reg;
    logic signed [68:0] s3_e_reg;
    logic signed [67:0] s3_p1_reg, s3_q1_reg;
    logic signed [66:0] s3_an_reg, s3_bn_reg;

    logic signed [101:0] pb_d1, pb_d2;
    logic signed [99:0]  pb_anax, pb_anay, pb_bnbx, pb_bnby;
    logic signed [99:0]  pb_p1ux, pb_p1uy, pb_q1ux, pb_q1uy;
    logic signed [131:0] pb_lhan, pb_twbn;
    logic signed [132:0] pb_lhp1, pb_twq1;
    b_t                  b_dl_reg [0:MUL_LAT-1];

    // stage 4 and 5
    c_t                  s4_reg, s5_reg;
    logic signed [134:0] pc_d3;
    c_t                  c_dl_reg [0:MUL_LAT-1];
    logic signed [134:0] s5_d3_reg;
    logic signed [135:0] s5_r4_reg;

    logic signed [165:0] pd_r1ax, pd_r1ay, pd_r2bx, pd_r2by;
    logic signed [167:0] pd_r4ux, pd_r4uy;
    d_t                  d_dl_reg [0:MUL_LAT-1];

    // stage 6: final numerators
    d_t                  s6_reg;
    logic signed [169:0] s6_n6_reg, s6_n7_reg;

    logic signed [Q_W-1:0] q0, q1, q2, q3, q4, q5, q6, q7, q8;
    logic                  dd_reg [0:DIV_LAT-1];

    logic signed [47:0] m11_reg, m12_reg, m14_reg, m21_reg, m22_reg, m24_reg;
    logic signed [47:0] m41_reg, m42_reg, m44_reg;
    logic               degenerate_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg   <= '0;
            rect_top_reg    <= '0;
            rect_width_reg  <= RESET_WIDTH;
            rect_height_reg <= RESET_HEIGHT;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_LEFT:   rect_left_reg   <= wr_data;
                REG_TOP:    rect_top_reg    <= wr_data;
                REG_WIDTH:  rect_width_reg  <= wr_data;
                REG_HEIGHT: rect_height_reg <= wr_data;
            endcase
        end
    end

    // valid shift line
    assign busy     = 1'b0;
    assign vld_next = {vld_reg[TOT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // corner differences relative to the upper-left corner
    always_ff @(posedge clk)
    begin
        s1_sd_reg.ax <= 33'(ur_x) - 33'(ul_x);
        s1_sd_reg.ay <= 33'(ur_y) - 33'(ul_y);
        s1_sd_reg.bx <= 33'(ll_x) - 33'(ul_x);
        s1_sd_reg.by <= 33'(ll_y) - 33'(ul_y);
        s1_sd_reg.ux <= ul_x;
        s1_sd_reg.uy <= ul_y;
        s1_sd_reg.w  <= signed'({1'b0, rect_width_reg});
        s1_sd_reg.h  <= signed'({1'b0, rect_height_reg});
        s1_dx_reg    <= 33'(lr_x) - 33'(ul_x);
        s1_dy_reg    <= 33'(lr_y) - 33'(ul_y);
        s1_l_reg     <= signed'(rect_left_reg);
        s1_t_reg     <= signed'(rect_top_reg);
        s1_whz_reg   <= (rect_width_reg == '0) || (rect_height_reg == '0);
    end

    // first multiplier bank: cross products and rectangle offsets
    qpm_mul #(.AW(33), .BW(33)) u_axby (.clk(clk), .a(s1_sd_reg.ax), .b(s1_sd_reg.by),
                                        .p(pa_axby));
    qpm_mul #(.AW(33), .BW(33)) u_aybx (.clk(clk), .a(s1_sd_reg.ay), .b(s1_sd_reg.bx),
                                        .p(pa_aybx));
    qpm_mul #(.AW(33), .BW(33)) u_bydx (.clk(clk), .a(s1_sd_reg.by), .b(s1_dx_reg),
                                        .p(pa_bydx));
    qpm_mul #(.AW(33), .BW(33)) u_bxdy (.clk(clk), .a(s1_sd_reg.bx), .b(s1_dy_reg),
                                        .p(pa_bxdy));
    qpm_mul #(.AW(33), .BW(33)) u_axdy (.clk(clk), .a(s1_sd_reg.ax), .b(s1_dy_reg),
                                        .p(pa_axdy));
    qpm_mul #(.AW(33), .BW(33)) u_aydx (.clk(clk), .a(s1_sd_reg.ay), .b(s1_dx_reg),
                                        .p(pa_aydx));
    qpm_mul #(.AW(33), .BW(32)) u_lh   (.clk(clk), .a(s1_sd_reg.h), .b(s1_l_reg),
                                        .p(pa_lh));
    qpm_mul #(.AW(33), .BW(32)) u_tw   (.clk(clk), .a(s1_sd_reg.w), .b(s1_t_reg),
                                        .p(pa_tw));

    always_ff @(posedge clk)
    begin
        a_dl_reg[0].sd  <= s1_sd_reg;
        a_dl_reg[0].whz <= s1_whz_reg;
        for (int k = 1; k < MUL_LAT; k++)
        begin
            a_dl_reg[k] <= a_dl_reg[k-1];
        end
    end

    // den, a and b numerators, then e, p1, q1 and the degenerate test
    always_ff @(posedge clk)
    begin
        s2_den_reg <= 67'(pa_axby) - 67'(pa_aybx);
        s2_an_reg  <= 67'(pa_bydx) - 67'(pa_bxdy);
        s2_bn_reg  <= 67'(pa_axdy) - 67'(pa_aydx);
        s2_lh_reg  <= pa_lh;
        s2_tw_reg  <= pa_tw;
        s2_sd_reg  <= a_dl_reg[MUL_LAT-1].sd;
        s2_whz_reg <= a_dl_reg[MUL_LAT-1].whz;

        s3_e_reg   <= 69'(s2_an_reg) + 69'(s2_bn_reg) - 69'(s2_den_reg);
        s3_p1_reg  <= 68'(s2_den_reg) - 68'(s2_bn_reg);
        s3_q1_reg  <= 68'(s2_den_reg) - 68'(s2_an_reg);
        s3_an_reg  <= s2_an_reg;
        s3_bn_reg  <= s2_bn_reg;
        s3_lh_reg  <= s2_lh_reg;
        s3_tw_reg  <= s2_tw_reg;
        s3_sd_reg  <= s2_sd_reg;
        s3_deg_reg <= s2_whz_reg || (s2_den_reg == '0)
                      || ((68'(s2_an_reg) + 68'(s2_bn_reg)) == 68'(s2_den_reg));
    end

    // second multiplier bank: denominators, first- and second-row terms and offset products
    qpm_mul #(.AW(69), .BW(33)) u_d1   (.clk(clk), .a(s3_e_reg), .b(s3_sd_reg.w),
                                        .p(pb_d1));
    qpm_mul #(.AW(69), .BW(33)) u_d2   (.clk(clk), .a(s3_e_reg), .b(s3_sd_reg.h),
                                        .p(pb_d2));
    qpm_mul #(.AW(67), .BW(33)) u_anax (.clk(clk), .a(s3_an_reg), .b(s3_sd_reg.ax),
                                        .p(pb_anax));
    qpm_mul #(.AW(67), .BW(33)) u_anay (.clk(clk), .a(s3_an_reg), .b(s3_sd_reg.ay),
                                        .p(pb_anay));
    qpm_mul #(.AW(67), .BW(33)) u_bnbx (.clk(clk), .a(s3_bn_reg), .b(s3_sd_reg.bx),
                                        .p(pb_bnbx));
    qpm_mul #(.AW(67), .BW(33)) u_bnby (.clk(clk), .a(s3_bn_reg), .b(s3_sd_reg.by),
                                        .p(pb_bnby));
    qpm_mul #(.AW(68), .BW(32)) u_p1ux (.clk(clk), .a(s3_p1_reg), .b(s3_sd_reg.ux),
                                        .p(pb_p1ux));
    qpm_mul #(.AW(68), .BW(32)) u_p1uy (.clk(clk), .a(s3_p1_reg), .b(s3_sd_reg.uy),
                                        .p(pb_p1uy));
    qpm_mul #(.AW(68), .BW(32)) u_q1ux (.clk(clk), .a(s3_q1_reg), .b(s3_sd_reg.ux),
                                        .p(pb_q1ux));
    qpm_mul #(.AW(68), .BW(32)) u_q1uy (.clk(clk), .a(s3_q1_reg), .b(s3_sd_reg.uy),
                                        .p(pb_q1uy));
    qpm_mul #(.AW(67), .BW(65)) u_lhan (.clk(clk), .a(s3_an_reg), .b(s3_lh_reg),
                                        .p(pb_lhan));
    qpm_mul #(.AW(67), .BW(65)) u_twbn (.clk(clk), .a(s3_bn_reg), .b(s3_tw_reg),
                                        .p(pb_twbn));
    qpm_mul #(.AW(68), .BW(65)) u_lhp1 (.clk(clk), .a(s3_p1_reg), .b(s3_lh_reg),
                                        .p(pb_lhp1));
    qpm_mul #(.AW(68), .BW(65)) u_twq1 (.clk(clk), .a(s3_q1_reg), .b(s3_tw_reg),
                                        .p(pb_twq1));

    always_ff @(posedge clk)
    begin
        b_dl_reg[0].sd  <= s3_sd_reg;
        b_dl_reg[0].deg <= s3_deg_reg;
        b_dl_reg[0].p1  <= s3_p1_reg;
        b_dl_reg[0].q1  <= s3_q1_reg;
        for (int k = 1; k < MUL_LAT; k++)
        begin
            b_dl_reg[k] <= b_dl_reg[k-1];
        end
    end

    // row sums, offset terms and the combined correction for r4
    always_ff @(posedge clk)
    begin
        s4_reg.sd  <= b_dl_reg[MUL_LAT-1].sd;
        s4_reg.deg <= b_dl_reg[MUL_LAT-1].deg;
        s4_reg.p1  <= b_dl_reg[MUL_LAT-1].p1;
        s4_reg.q1  <= b_dl_reg[MUL_LAT-1].q1;
        s4_reg.n0  <= 101'(pb_anax) + 101'(pb_p1ux);
        s4_reg.n1  <= 101'(pb_anay) + 101'(pb_p1uy);
        s4_reg.n3  <= 101'(pb_bnbx) + 101'(pb_q1ux);
        s4_reg.n4  <= 101'(pb_bnby) + 101'(pb_q1uy);
        s4_reg.d1  <= pb_d1;
        s4_reg.d2  <= pb_d2;
        s4_reg.r1  <= -133'(pb_lhan);
        s4_reg.r2  <= -133'(pb_twbn);
        s4_reg.ts  <= 134'(pb_lhp1) + 134'(pb_twq1);
    end

    // third multiplier: full denominator
    qpm_mul #(.AW(102), .BW(33)) u_d3 (.clk(clk), .a(s4_reg.d1), .b(s4_reg.sd.h),
                                       .p(pc_d3));

    always_ff @(posedge clk)
    begin
        c_dl_reg[0] <= s4_reg;
        for (int k = 1; k < MUL_LAT; k++)
        begin
            c_dl_reg[k] <= c_dl_reg[k-1];
        end
        s5_reg    <= c_dl_reg[MUL_LAT-1];
        s5_d3_reg <= pc_d3;
        s5_r4_reg <= 136'(pc_d3) - 136'(c_dl_reg[MUL_LAT-1].ts);
    end

    // fourth multiplier bank: offset row
    qpm_mul #(.AW(133), .BW(33)) u_r1ax (.clk(clk), .a(s5_reg.r1), .b(s5_reg.sd.ax),
                                         .p(pd_r1ax));
    qpm_mul #(.AW(133), .BW(33)) u_r1ay (.clk(clk), .a(s5_reg.r1), .b(s5_reg.sd.ay),
                                         .p(pd_r1ay));
    qpm_mul #(.AW(133), .BW(33)) u_r2bx (.clk(clk), .a(s5_reg.r2), .b(s5_reg.sd.bx),
                                         .p(pd_r2bx));
    qpm_mul #(.AW(133), .BW(33)) u_r2by (.clk(clk), .a(s5_reg.r2), .b(s5_reg.sd.by),
                                         .p(pd_r2by));
    qpm_mul #(.AW(136), .BW(32)) u_r4ux (.clk(clk), .a(s5_r4_reg), .b(s5_reg.sd.ux),
                                         .p(pd_r4ux));
    qpm_mul #(.AW(136), .BW(32)) u_r4uy (.clk(clk), .a(s5_r4_reg), .b(s5_reg.sd.uy),
                                         .p(pd_r4uy));

    always_ff @(posedge clk)
    begin
        d_dl_reg[0].deg <= s5_reg.deg;
        d_dl_reg[0].n0  <= s5_reg.n0;
        d_dl_reg[0].n1  <= s5_reg.n1;
        d_dl_reg[0].n3  <= s5_reg.n3;
        d_dl_reg[0].n4  <= s5_reg.n4;
        d_dl_reg[0].d1  <= s5_reg.d1;
        d_dl_reg[0].d2  <= s5_reg.d2;
        d_dl_reg[0].d3  <= s5_d3_reg;
        d_dl_reg[0].r4  <= s5_r4_reg;
        d_dl_reg[0].p1  <= s5_reg.p1;
        d_dl_reg[0].q1  <= s5_reg.q1;
        for (int k = 1; k < MUL_LAT; k++)
        begin
            d_dl_reg[k] <= d_dl_reg[k-1];
        end
        s6_reg    <= d_dl_reg[MUL_LAT-1];
        s6_n6_reg <= 170'(pd_r1ax) + 170'(pd_r2bx) + 170'(pd_r4ux);
        s6_n7_reg <= 170'(pd_r1ay) + 170'(pd_r2by) + 170'(pd_r4uy);
    end

    // nine dividers, scaled numerators
    qpm_div #(.NW(125), .DW(102)) u_div0 (.clk(clk), .num({s6_reg.n0, 24'd0}),
                                          .den(s6_reg.d1), .quo(q0));
    qpm_div #(.NW(125), .DW(102)) u_div1 (.clk(clk), .num({s6_reg.n1, 24'd0}),
                                          .den(s6_reg.d1), .quo(q1));
    qpm_div #(.NW(108), .DW(102)) u_div2 (.clk(clk), .num({s6_reg.p1, 40'd0}),
                                          .den(s6_reg.d1), .quo(q2));
    qpm_div #(.NW(125), .DW(102)) u_div3 (.clk(clk), .num({s6_reg.n3, 24'd0}),
                                          .den(s6_reg.d2), .quo(q3));
    qpm_div #(.NW(125), .DW(102)) u_div4 (.clk(clk), .num({s6_reg.n4, 24'd0}),
                                          .den(s6_reg.d2), .quo(q4));
    qpm_div #(.NW(108), .DW(102)) u_div5 (.clk(clk), .num({s6_reg.q1, 40'd0}),
                                          .den(s6_reg.d2), .quo(q5));
    qpm_div #(.NW(178), .DW(135)) u_div6 (.clk(clk), .num({s6_n6_reg, 8'd0}),
                                          .den(s6_reg.d3), .quo(q6));
    qpm_div #(.NW(178), .DW(135)) u_div7 (.clk(clk), .num({s6_n7_reg, 8'd0}),
                                          .den(s6_reg.d3), .quo(q7));
    qpm_div #(.NW(160), .DW(135)) u_div8 (.clk(clk), .num({s6_reg.r4, 24'd0}),
                                          .den(s6_reg.d3), .quo(q8));

    // degenerate flag alongside the dividers, then the output register
    always_ff @(posedge clk)
    begin
        dd_reg[0] <= s6_reg.deg;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            dd_reg[k] <= dd_reg[k-1];
        end
        m11_reg        <= dd_reg[DIV_LAT-1] ? '0 : q0;
        m12_reg        <= dd_reg[DIV_LAT-1] ? '0 : q1;
        m14_reg        <= dd_reg[DIV_LAT-1] ? '0 : q2;
        m21_reg        <= dd_reg[DIV_LAT-1] ? '0 : q3;
        m22_reg        <= dd_reg[DIV_LAT-1] ? '0 : q4;
        m24_reg        <= dd_reg[DIV_LAT-1] ? '0 : q5;
        m41_reg        <= dd_reg[DIV_LAT-1] ? '0 : q6;
        m42_reg        <= dd_reg[DIV_LAT-1] ? '0 : q7;
        m44_reg        <= dd_reg[DIV_LAT-1] ? '0 : q8;
        degenerate_reg <= dd_reg[DIV_LAT-1];
    end

    assign done       = vld_reg[TOT-1];
    assign m11        = m11_reg;
    assign m12        = m12_reg;
    assign m14        = m14_reg;
    assign m21        = m21_reg;
    assign m22        = m22_reg;
    assign m24        = m24_reg;
    assign m41        = m41_reg;
    assign m42        = m42_reg;
    assign m44        = m44_reg;
    assign degenerate = degenerate_reg;

endmodule

// File: bench/tb_quad_perspective_matrix_setup_core.sv
// testbench for the quad perspective matrix setup core with an exact wide-integer predictor
module tb_quad_perspective_matrix_setup_core;
    import qpm_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [31:0] ulx, uly, urx, ury, llx, lly, lrx, lry;
    } quad_t;

    typedef struct {
        logic [47:0] m [9];
        logic        degen;
    } matrix_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 120;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;
    logic signed [31:0] ul_x, ul_y, ur_x, ur_y, ll_x, ll_y, lr_x, lr_y;
    logic done;
    logic signed [47:0] m11, m12, m14, m21, m22, m24, m41, m42, m44;
    logic degenerate;

    // mirror of the rectangle registers
    logic signed [31:0] rect_l, rect_t;
    logic [31:0] rect_w, rect_h;

    quad_t   pending_quads [$];
    matrix_t expected_matrices [$];
    quad_t   cur_quad;
    int      idle_pct;
    int      errors;
    int      requests_taken;
    int      matrices_seen;
    int      degen_seen;
    int      quiet_cycles;
    logic    requests_taken_flag;
    string   entry_names [9] = '{"m11", "m12", "m14", "m21", "m22", "m24", "m41", "m42", "m44"};

    quad_perspective_matrix_setup_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .ul_x(ul_x), .ul_y(ul_y), .ur_x(ur_x), .ur_y(ur_y),
        .ll_x(ll_x), .ll_y(ll_y), .lr_x(lr_x), .lr_y(lr_y),
        .done(done),
        .m11(m11), .m12(m12), .m14(m14), .m21(m21), .m22(m22), .m24(m24),
        .m41(m41), .m42(m42), .m44(m44), .degenerate(degenerate)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // exact quotient rounded half away from zero, saturated to 48 bits
    function automatic logic [47:0] round_sat_div(wide_t n, wide_t d);
        wide_t mag_n, mag_d, q, r, lim;
        logic neg;
        neg   = n[255] ^ d[255];
        mag_n = n[255] ? -n : n;
        mag_d = d[255] ? -d : d;
        q     = mag_n / mag_d;
        r     = mag_n - q * mag_d;
        if (2 * r >= mag_d)
            q = q + 1;
        lim = neg ? (wide_t'(1) <<< 47) : ((wide_t'(1) <<< 47) - 1);
        if (q > lim)
            q = lim;
        if (neg)
            q = -q;
        return q[47:0];
    endfunction

    // square-to-quad matrix from the corners and the current rectangle
    function automatic matrix_t perspective_matrix(quad_t c);
        matrix_t res;
        wide_t ux, uy, ax, ay, bx, by, dx, dy, w, h, l, t;
        wide_t den, an, bn, e, p1, q1, d1, d2, d3, r1, r2, r4;
        ux  = c.ulx;
        uy  = c.uly;
        ax  = c.urx; ax = ax - ux;
        ay  = c.ury; ay = ay - uy;
        bx  = c.llx; bx = bx - ux;
        by  = c.lly; by = by - uy;
        dx  = c.lrx; dx = dx - ux;
        dy  = c.lry; dy = dy - uy;
        w   = {224'b0, rect_w};
        h   = {224'b0, rect_h};
        l   = rect_l;
        t   = rect_t;
        den = ax * by - ay * bx;
        an  = by * dx - bx * dy;
        bn  = ax * dy - ay * dx;
        e   = an + bn - den;
        for (int i = 0; i < 9; i++)
            res.m[i] = '0;
        res.degen = 1'b1;
        if (den == 0 || e == 0 || rect_w == 0 || rect_h == 0)
            return res;
        res.degen = 1'b0;
        p1 = den - bn;
        q1 = den - an;
        d1 = e * w;
        d2 = e * h;
        d3 = d1 * h;
        res.m[0] = round_sat_div((an * ax + p1 * ux) <<< 24, d1);
        res.m[1] = round_sat_div((an * ay + p1 * uy) <<< 24, d1);
        res.m[2] = round_sat_div(p1 <<< 40, d1);
        res.m[3] = round_sat_div((bn * bx + q1 * ux) <<< 24, d2);
        res.m[4] = round_sat_div((bn * by + q1 * uy) <<< 24, d2);
        res.m[5] = round_sat_div(q1 <<< 40, d2);
        r1 = -(l * h * an);
        r2 = -(t * w * bn);
        r4 = d3 - l * h * p1 - t * w * q1;
        res.m[6] = round_sat_div((r1 * ax + r2 * bx + r4 * ux) <<< 8, d3);
        res.m[7] = round_sat_div((r1 * ay + r2 * by + r4 * uy) <<< 8, d3);
        res.m[8] = round_sat_div(r4 <<< 24, d3);
        return res;
    endfunction

    // request driver, inputs change on the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || requests_taken_flag)
        begin
            if (pending_quads.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                cur_quad = pending_quads.pop_front();
                ul_x <= cur_quad.ulx; ul_y <= cur_quad.uly;
                ur_x <= cur_quad.urx; ur_y <= cur_quad.ury;
                ll_x <= cur_quad.llx; ll_y <= cur_quad.lly;
                lr_x <= cur_quad.lrx; lr_y <= cur_quad.lry;
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predict on each request, check each done strobe
    always @(posedge clk)
    begin
        matrix_t exp_m;
        logic [47:0] got [9];
        requests_taken_flag = 1'b0;
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (start && !busy)
            begin
                expected_matrices.push_back(perspective_matrix(cur_quad));
                requests_taken_flag = 1'b1;
                requests_taken = requests_taken + 1;
                quiet_cycles = 0;
            end
            if (wr_en)
            begin
                case (reg_idx_t'(wr_index))
                    REG_LEFT:   rect_l = wr_data;
                    REG_TOP:    rect_t = wr_data;
                    REG_WIDTH:  rect_w = wr_data;
                    REG_HEIGHT: rect_h = wr_data;
                    default: ;
                endcase
            end
            if (done)
            begin
                quiet_cycles = 0;
                matrices_seen = matrices_seen + 1;
                if (expected_matrices.size() == 0)
                begin
                    $error("matrix result with no request outstanding");
                    errors = errors + 1;
                end
                else
                begin
                    exp_m = expected_matrices.pop_front();
                    got = '{m11, m12, m14, m21, m22, m24, m41, m42, m44};
                    if (exp_m.degen)
                        degen_seen = degen_seen + 1;
                    for (int i = 0; i < 9; i++)
                    begin
                        if (got[i] !== exp_m.m[i])
                        begin
                            $error("%s expected %h got %h", entry_names[i], exp_m.m[i], got[i]);
                            errors = errors + 1;
                        end
                    end
                    if (degenerate !== exp_m.degen)
                    begin
                        $error("degenerate expected %b got %b", exp_m.degen, degenerate);
                        errors = errors + 1;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("tb_quad_perspective_matrix_setup_core failed");
                $finish;
            end
        end
    end

    function automatic quad_t corners(int ulx, int uly, int urx, int ury,
                                      int llx, int lly, int lrx, int lry);
        quad_t c;
        c.ulx = ulx; c.uly = uly; c.urx = urx; c.ury = ury;
        c.llx = llx; c.lly = lly; c.lrx = lrx; c.lry = lry;
        return c;
    endfunction

    // random quad: mostly plausible shapes, some full-range noise and degenerate ones
    function automatic quad_t random_quad();
        quad_t c;
        int sel;
        int span;
        sel = $urandom_range(99);
        if (sel < 60)
        begin
            span = 1 << $urandom_range(10, 26);
            c.ulx = $urandom_range(span); c.uly = $urandom_range(span);
            c.urx = span + $urandom_range(span); c.ury = $urandom_range(span);
            c.llx = $urandom_range(span); c.lly = span + $urandom_range(span);
            c.lrx = span + $urandom_range(span); c.lry = span + $urandom_range(span);
            if ($urandom_range(1))
                c.ulx = -c.ulx;
            if ($urandom_range(1))
                c.lly = -c.lly;
        end
        else if (sel < 85)
        begin
            c = corners($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
        end
        else if (sel < 92)
        begin
            // lower-right on the upper-right corner, so a+b-1 vanishes
            c = corners($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, 0, 0);
            c.lrx = c.urx;
            c.lry = c.ury;
        end
        else
        begin
            // collinear corners, den is zero
            span = $urandom_range(1, 1000);
            c = corners(span, span, 2 * span, 2 * span, 3 * span, 3 * span,
                        $urandom, $urandom);
        end
        return c;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
    endtask

    task automatic set_rect(logic [31:0] l, logic [31:0] t, logic [31:0] w, logic [31:0] h);
        write_reg(REG_LEFT, l);
        write_reg(REG_TOP, t);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    // wait until every expected matrix has come back, then let the pipeline settle
    task automatic drain();
        wait (pending_quads.size() == 0 && !start && expected_matrices.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random(int count, int pct);
        idle_pct = pct;
        for (int i = 0; i < count; i++)
            pending_quads.push_back(random_quad());
        drain();
    endtask

    // stimulus sequence
    initial
    begin
        int one;
        one = 65536;
        rst_n = 1'b0;
        start = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        {ul_x, ul_y, ur_x, ur_y, ll_x, ll_y, lr_x, lr_y} = '0;
        rect_l = '0;
        rect_t = '0;
        rect_w = RESET_WIDTH;
        rect_h = RESET_HEIGHT;
        errors = 0;
        requests_taken = 0;
        matrices_seen = 0;
        degen_seen = 0;
        quiet_cycles = 0;
        requests_taken_flag = 1'b0;
        idle_pct = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed requests under the reset rectangle
        pending_quads.push_back(corners(0, 0, 0, 0, 0, 0, 0, 0));
        pending_quads.push_back(corners(0, 0, 320 * one, 0, 0, 400 * one, 320 * one, 400 * one));
        pending_quads.push_back(corners(10 * one, 20 * one, 300 * one, 5 * one,
                                        -7 * one, 390 * one, 330 * one, 420 * one));
        pending_quads.push_back(corners(0, 0, one, 0, 0, one, one, 0));
        pending_quads.push_back(corners(one, 2 * one, 5 * one, 3 * one,
                                        2 * one, 9 * one, 5 * one, 3 * one));
        pending_quads.push_back(corners(one, one, 2 * one, 2 * one,
                                        3 * one, 3 * one, 7 * one, -one));
        pending_quads.push_back(corners(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                        32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending_quads.push_back(corners(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                        32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000));
        pending_quads.push_back(corners(32'h80000000, 0, 32'h7fffffff, 0,
                                        0, 32'h7fffffff, 1, 1));
        pending_quads.push_back(corners(-1, -1, 1, 0, 0, 1, 32'h7fffffff, 32'h80000000));
        pending_quads.push_back(corners(0, 0, 1, 0, 0, 1, 32'h40000000, 32'h40000000));
        pending_quads.push_back(corners(0, 0, 2, 0, 0, 2, 1, 1));
        drain();
        run_random(300, 0);

        // extreme rectangle, smallest size
        set_rect(32'h80000000, 32'h7fffffff, 32'h00010000, 32'h00010000);
        run_random(250, 75);

        // extreme rectangle, largest size
        set_rect(32'h7fffffff, 32'h80000000, 32'hffff0000, 32'hffff0000);
        pending_quads.push_back(corners(0, 0, 320 * one, 0, 0, 400 * one, 320 * one, 400 * one));
        run_random(250, 22);

        // random rectangles
        set_rect($urandom, $urandom, $urandom_range(32'hffff0000, 32'h10000),
                 $urandom_range(32'h00ff0000, 32'h10000));
        run_random(250, 0);
        set_rect($urandom_range(1000) * one, -$urandom_range(1000) * one,
                 $urandom_range(2000, 1) * one, $urandom_range(2000, 1) * one);
        run_random(250, 75);

        $display("%0d matrix requests over five rectangle settings, %0d results, %0d degenerate",
                 requests_taken, matrices_seen, degen_seen);
        if (errors == 0)
            $display("tb_quad_perspective_matrix_setup_core passed");
        else
            $display("tb_quad_perspective_matrix_setup_core failed");
        $finish;
    end

endmodule
